FILE: rtl/core/assert_macros.svh
// Assertion macros for the timer RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

FILE: rtl/core/dtt_pkg.sv
`default_nettype none

package dtt_pkg;

  // Command codes carried by one input word
  typedef enum logic [1:0] {
    CmdTick    = 2'd0,
    CmdRead    = 2'd1,
    CmdWrite   = 2'd2,
    CmdTakeIrq = 2'd3
  } cmd_e;

  // Sequencer states
  typedef enum logic {
    StIdle = 1'b0,
    StRun  = 1'b1
  } state_e;

  // Register addresses
  localparam logic [15:0] AddrDiv  = 16'hFF04;
  localparam logic [15:0] AddrTima = 16'hFF05;
  localparam logic [15:0] AddrTma  = 16'hFF06;
  localparam logic [15:0] AddrTac  = 16'hFF07;

  // Control register fields
  localparam logic [2:0] TacEnable = 3'h4;
  localparam logic [2:0] TacMask   = 3'h7;
  localparam logic [2:0] TacSel    = 3'h3;

  localparam int unsigned DivW   = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TacW   = 3;

  // Sequencer to datapath control
  typedef struct packed {
    logic accept;  // input word taken this cycle
    logic step;    // advance the divider by one
    logic last;    // final divider step of a tick word
  } seq_ctrl_t;

  // Timer signal: selected divider bit gated by the enable bit
  function automatic logic timer_sig(input logic [DivW-1:0] div, input logic [TacW-1:0] tac);
    logic b;
    case (tac & TacSel)
      3'd0:    b = div[9];
      3'd1:    b = div[3];
      3'd2:    b = div[5];
      3'd3:    b = div[7];
      default: b = 1'b0;
    endcase
    return b & ((tac & TacEnable) != 3'd0);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/div_tima_timer.sv
// Timing: bus read, bus write, take-interrupt and zero-count tick words strobe done_o
// in the cycle after the accepting edge. A tick word of n > 0 steps the divider once per
// cycle in the shared edge unit and strobes done_o once its final step is registered;
// busy_o is high meanwhile. Throughput: one word per cycle while busy_o is low; results
// are strobed on done_o for one cycle and the receiver cannot stall.
// Async active-low reset zeroes all state.
`default_nettype none

`include "assert_macros.svh"

module div_tima_timer import dtt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       cmd_i,
  input  logic [ByteW-1:0] tick_count_i,
  input  logic [15:0]      bus_address_i,
  input  logic [ByteW-1:0] write_data_i,
  output logic             done_o,
  output logic [ByteW-1:0] read_data_o,
  output logic             hit_o,
  output logic             irq_o
);

  seq_ctrl_t ctrl;

  logic [DivW-1:0]  divider_q, divider_d;
  logic [ByteW-1:0] counter_q, counter_d;
  logic [ByteW-1:0] reload_q, reload_d;
  logic [TacW-1:0]  tac_q, tac_d;
  logic             irq_flag_q, irq_flag_d;

  logic             done_q, done_d;
  logic [ByteW-1:0] rdata_q, rdata_d;
  logic             hit_q, hit_d;
  logic             irq_q, irq_d;

  logic [DivW-1:0]  div_new;
  logic [TacW-1:0]  tac_new;
  logic [ByteW-1:0] unit_counter;
  logic             unit_irq;

  dtt_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .cmd_i        (cmd_i),
    .tick_count_i (tick_count_i),
    .busy_o       (busy_o),
    .ctrl_o       (ctrl)
  );

  dtt_step_unit u_step (
    .div_old_i (divider_q),
    .tac_old_i (tac_q),
    .div_new_i (div_new),
    .tac_new_i (tac_new),
    .counter_i (counter_q),
    .reload_i  (reload_q),
    .counter_o (unit_counter),
    .irq_set_o (unit_irq)
  );

  // Apply a divider step or the accepted word to the timer state
  always_comb begin
    divider_d  = divider_q;
    counter_d  = counter_q;
    reload_d   = reload_q;
    tac_d      = tac_q;
    irq_flag_d = irq_flag_q;
    div_new    = divider_q;
    tac_new    = tac_q;
    rdata_d    = '0;
    hit_d      = 1'b0;
    irq_d      = 1'b0;
    done_d     = 1'b0;

    if (ctrl.step) begin
      div_new    = divider_q + {{(DivW-1){1'b0}}, 1'b1};
      divider_d  = div_new;
      counter_d  = unit_counter;
      irq_flag_d = irq_flag_q | unit_irq;
      done_d     = ctrl.last;
    end else if (ctrl.accept) begin
      done_d = !((cmd_i == CmdTick) && (tick_count_i != '0));
      case (cmd_i)
        CmdRead: begin
          hit_d = 1'b1;
          case (bus_address_i)
            AddrDiv:  rdata_d = divider_q[DivW-1 -: ByteW];
            AddrTima: rdata_d = counter_q;
            AddrTma:  rdata_d = reload_q;
            AddrTac:  rdata_d = {{(ByteW-TacW){1'b0}}, tac_q};
            default:  hit_d = 1'b0;
          endcase
        end
        CmdWrite: begin
          hit_d = 1'b1;
          case (bus_address_i)
            AddrDiv: begin
              div_new    = '0;
              divider_d  = '0;
              counter_d  = unit_counter;
              irq_flag_d = irq_flag_q | unit_irq;
            end
            AddrTima: counter_d = write_data_i;
            AddrTma:  reload_d  = write_data_i;
            AddrTac: begin
              tac_new    = write_data_i[TacW-1:0] & TacMask;
              tac_d      = tac_new;
              counter_d  = unit_counter;
              irq_flag_d = irq_flag_q | unit_irq;
            end
            default: hit_d = 1'b0;
          endcase
        end
        CmdTakeIrq: begin
          irq_d      = irq_flag_q;
          irq_flag_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divider_q  <= '0;
      counter_q  <= '0;
      reload_q   <= '0;
      tac_q      <= '0;
      irq_flag_q <= 1'b0;
      done_q     <= 1'b0;
      rdata_q    <= '0;
      hit_q      <= 1'b0;
      irq_q      <= 1'b0;
    end else begin
      divider_q  <= divider_d;
      counter_q  <= counter_d;
      reload_q   <= reload_d;
      tac_q      <= tac_d;
      irq_flag_q <= irq_flag_d;
      done_q     <= done_d;
      rdata_q    <= rdata_d;
      hit_q      <= hit_d;
      irq_q      <= irq_d;
    end
  end

  assign done_o      = done_q;
  assign read_data_o = rdata_q;
  assign hit_o       = hit_q;
  assign irq_o       = irq_q;

  // Result strobe never overlaps a running tick
  `ASSERT_NEVER(a_done_not_busy, done_o && busy_o, "result strobe while busy")
  // A run starts only from an accepted word
  `ASSERT_PROP(a_busy_from_start, $rose(busy_o) |-> $past(start_i), "busy without start")
  // Taking the interrupt clears the flag
  `ASSERT_PROP(a_take_clears, (ctrl.accept && (cmd_i == CmdTakeIrq)) |=> !irq_flag_q,
               "interrupt flag not cleared")
  // Bus fields and interrupt result are exclusive
  `ASSERT_NEVER(a_irq_excl, irq_o && (hit_o || (read_data_o != '0)), "irq with bus result")

endmodule

`default_nettype wire

FILE: rtl/core/dtt_step_unit.sv
`default_nettype none

// Shared edge unit: compare the timer signal before and after a change of
// divider or control, and count the counter on a falling edge.
module dtt_step_unit import dtt_pkg::*; (
  input  logic [DivW-1:0]  div_old_i,
  input  logic [TacW-1:0]  tac_old_i,
  input  logic [DivW-1:0]  div_new_i,
  input  logic [TacW-1:0]  tac_new_i,
  input  logic [ByteW-1:0] counter_i,
  input  logic [ByteW-1:0] reload_i,
  output logic [ByteW-1:0] counter_o,
  output logic             irq_set_o
);

  logic             fall;
  logic [ByteW:0]   inc;

  // Detect the falling edge of the timer signal
  assign fall = timer_sig(div_old_i, tac_old_i) & ~timer_sig(div_new_i, tac_new_i);

  // Increment, reload on overflow
  assign inc = {1'b0, counter_i} + {{ByteW{1'b0}}, 1'b1};

  always_comb begin
    counter_o = counter_i;
    irq_set_o = 1'b0;
    if (fall) begin
      if (inc[ByteW]) begin
        counter_o = reload_i;
        irq_set_o = 1'b1;
      end else begin
        counter_o = inc[ByteW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dtt_seq.sv
`default_nettype none

// Sequencer: take a word, then run one divider step per cycle for a tick.
module dtt_seq import dtt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       cmd_i,
  input  logic [ByteW-1:0] tick_count_i,
  output logic             busy_o,
  output seq_ctrl_t        ctrl_o
);

  state_e           state_q, state_d;
  logic [ByteW-1:0] remain_q, remain_d;
  logic             accept;

  assign accept = start_i && (state_q == StIdle);

  // Next state
  always_comb begin
    state_d  = state_q;
    remain_d = remain_q;
    case (state_q)
      StIdle: begin
        if (accept && (cmd_i == CmdTick) && (tick_count_i != '0)) begin
          state_d  = StRun;
          remain_d = tick_count_i;
        end
      end
      StRun: begin
        remain_d = remain_q - {{(ByteW-1){1'b0}}, 1'b1};
        if (remain_q == {{(ByteW-1){1'b0}}, 1'b1}) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    busy_o        = (state_q == StRun);
    ctrl_o.accept = accept;
    ctrl_o.step   = (state_q == StRun);
    ctrl_o.last   = (state_q == StRun) && (remain_q == {{(ByteW-1){1'b0}}, 1'b1});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      remain_q <= '0;
    end else begin
      state_q  <= state_d;
      remain_q <= remain_d;
    end
  end

endmodule

`default_nettype wire

FILE: dv/div_tima_timer_test.sv
`timescale 1ns / 1ps

module div_tima_timer_test;
  import dtt_pkg::*;

  localparam int unsigned RandomWords = 1350;
  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  ticks;
    logic [15:0] addr;
    logic [7:0]  data;
  } timer_word_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       hit;
    logic       irq;
  } timer_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start_i       = 1'b0;
  logic [1:0]  cmd_i         = CmdTick;
  logic [7:0]  tick_count_i  = '0;
  logic [15:0] bus_address_i = '0;
  logic [7:0]  write_data_i  = '0;
  logic        busy_o;
  logic        done_o;
  logic [7:0]  read_data_o;
  logic        hit_o;
  logic        irq_o;

  // Shadow copy of the timer state
  logic [15:0] div_q  = '0;
  logic [7:0]  tima_q = '0;
  logic [7:0]  tma_q  = '0;
  logic [2:0]  tac_q  = '0;
  logic        irq_q  = 1'b0;

  timer_word_t   pending_words[$];
  timer_result_t expected_results[$];
  int unsigned   fail_count  = 0;
  int unsigned   cycle_count = 0;

  div_tima_timer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .tick_count_i (tick_count_i),
    .bus_address_i(bus_address_i),
    .write_data_i (write_data_i),
    .done_o       (done_o),
    .read_data_o  (read_data_o),
    .hit_o        (hit_o),
    .irq_o        (irq_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Timer signal: tapped divider bit gated by the enable bit
  function automatic logic timer_level(input logic [15:0] div, input logic [2:0] tac);
    int unsigned tap;
    case (tac[1:0])
      2'd0:    tap = 9;
      2'd1:    tap = 3;
      2'd2:    tap = 5;
      default: tap = 7;
    endcase
    return div[tap] && ((tac & TacEnable) != '0);
  endfunction

  // Bump the counter; wrap reloads it and raises the flag
  task automatic count_timer_edge();
    tima_q = tima_q + 8'd1;
    if (tima_q == 8'd0) begin
      tima_q = tma_q;
      irq_q  = 1'b1;
    end
  endtask

  // Advance the shadow state by one word and queue the result it produces
  task automatic apply_word(input timer_word_t w);
    timer_result_t r;
    logic          was_high;
    r = '0;
    case (w.cmd)
      CmdTick: begin
        for (int i = 0; i < w.ticks; i++) begin
          was_high = timer_level(div_q, tac_q);
          div_q    = div_q + 16'd1;
          if (was_high && !timer_level(div_q, tac_q)) count_timer_edge();
        end
      end
      CmdRead: begin
        r.hit = 1'b1;
        if (w.addr == AddrDiv) r.rd = div_q[15:8];
        else if (w.addr == AddrTima) r.rd = tima_q;
        else if (w.addr == AddrTma) r.rd = tma_q;
        else if (w.addr == AddrTac) r.rd = {5'd0, tac_q};
        else r.hit = 1'b0;
      end
      CmdWrite: begin
        r.hit    = 1'b1;
        was_high = timer_level(div_q, tac_q);
        if (w.addr == AddrDiv) begin
          div_q = '0;
          if (was_high && !timer_level(div_q, tac_q)) count_timer_edge();
        end else if (w.addr == AddrTima) begin
          tima_q = w.data;
        end else if (w.addr == AddrTma) begin
          tma_q = w.data;
        end else if (w.addr == AddrTac) begin
          tac_q = w.data[2:0] & TacMask;
          if (was_high && !timer_level(div_q, tac_q)) count_timer_edge();
        end else begin
          r.hit = 1'b0;
        end
      end
      default: begin
        r.irq = irq_q;
        irq_q = 1'b0;
      end
    endcase
    expected_results.push_back(r);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= ReportLimit) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic timer_word_t make_word(input cmd_e c, input logic [7:0] ticks,
                                            input logic [15:0] addr, input logic [7:0] data);
    timer_word_t w;
    w.cmd   = c;
    w.ticks = ticks;
    w.addr  = addr;
    w.data  = data;
    return w;
  endfunction

  function automatic logic [15:0] pick_address();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return AddrDiv;
    if (roll < 40) return AddrTima;
    if (roll < 62) return AddrTma;
    if (roll < 88) return AddrTac;
    if (roll < 94) return 16'hFF00 + 16'($urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  // Mostly short ticks and decoded accesses, biased to reach counter wrap
  function automatic timer_word_t random_word();
    timer_word_t w;
    int unsigned roll;
    w.ticks = 8'($urandom);
    w.addr  = 16'($urandom);
    w.data  = 8'($urandom);
    roll    = $urandom_range(0, 99);
    if (roll < 42) begin
      w.cmd = CmdTick;
      roll  = $urandom_range(0, 99);
      if (roll < 70) w.ticks = 8'($urandom_range(0, 8));
      else if (roll < 95) w.ticks = 8'($urandom_range(9, 40));
    end else if (roll < 64) begin
      w.cmd  = CmdRead;
      w.addr = pick_address();
    end else if (roll < 88) begin
      w.cmd  = CmdWrite;
      w.addr = pick_address();
      if (w.addr == AddrTima && $urandom_range(0, 1) == 0) w.data = 8'($urandom_range(240, 255));
      if (w.addr == AddrTac && $urandom_range(0, 99) < 60) w.data[2] = 1'b1;
    end else begin
      w.cmd = CmdTakeIrq;
    end
    return w;
  endfunction

  // Drive words in bursts with random gaps; hold a word until it is taken
  always @(posedge clk_i) begin : word_driver
    timer_word_t cur_word;
    int unsigned gap_left;
    int unsigned burst_left;
    if (!rst_ni) begin
      start_i    <= 1'b0;
      gap_left   = 0;
      burst_left = $urandom_range(1, 20);
    end else begin
      if (start_i && !busy_o) begin
        apply_word(cur_word);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 12);
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 20);
        end
      end
      if (!start_i || !busy_o) begin
        if (gap_left != 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          cmd_i         <= cur_word.cmd;
          tick_count_i  <= cur_word.ticks;
          bus_address_i <= cur_word.addr;
          write_data_i  <= cur_word.data;
          start_i       <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Check each strobed result against the oldest expectation
  always @(posedge clk_i) begin : result_monitor
    timer_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result rd=%02h hit=%0b irq=%0b",
                               read_data_o, hit_o, irq_o));
      end else begin
        want = expected_results.pop_front();
        if (want.rd !== read_data_o || want.hit !== hit_o || want.irq !== irq_o)
          note_failure($sformatf({"mismatch: expected rd=%02h hit=%0b irq=%0b, ",
                                  "got rd=%02h hit=%0b irq=%0b"},
                                 want.rd, want.hit, want.irq, read_data_o, hit_o, irq_o));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    // Reset values, undecoded addresses and a zero tick
    pending_words.push_back(make_word(CmdRead, 8'h00, AddrDiv, 8'h00));
    pending_words.push_back(make_word(CmdRead, 8'h00, AddrTima, 8'h00));
    pending_words.push_back(make_word(CmdRead, 8'h00, AddrTma, 8'h00));
    pending_words.push_back(make_word(CmdRead, 8'h00, AddrTac, 8'h00));
    pending_words.push_back(make_word(CmdRead, 8'hFF, 16'hFF03, 8'hFF));
    pending_words.push_back(make_word(CmdWrite, 8'hFF, 16'h0000, 8'hFF));
    pending_words.push_back(make_word(CmdRead, 8'h00, 16'hFFFF, 8'h00));
    pending_words.push_back(make_word(CmdTick, 8'h00, 16'hFFFF, 8'hFF));
    // Enable on the fastest tap with the counter near wrap; masked control data
    pending_words.push_back(make_word(CmdWrite, 8'h00, AddrTma, 8'hAB));
    pending_words.push_back(make_word(CmdWrite, 8'h00, AddrTima, 8'hFE));
    pending_words.push_back(make_word(CmdWrite, 8'h00, AddrTac, 8'hFD));
    pending_words.push_back(make_word(CmdRead, 8'h00, AddrTac, 8'h00));
    pending_words.push_back(make_word(CmdTick, 8'hFF, 16'h0000, 8'h00));
    pending_words.push_back(make_word(CmdRead, 8'h00, AddrTima, 8'h00));
    // Take the flag twice: set, then cleared
    pending_words.push_back(make_word(CmdTakeIrq, 8'hFF, 16'hFFFF, 8'hFF));
    pending_words.push_back(make_word(CmdTakeIrq, 8'h00, 16'h0000, 8'h00));
    // Divider clear and control rewrite while the timer signal is high
    pending_words.push_back(make_word(CmdWrite, 8'h00, AddrDiv, 8'h5A));
    pending_words.push_back(make_word(CmdTick, 8'h08, 16'h0000, 8'h00));
    pending_words.push_back(make_word(CmdWrite, 8'h00, AddrTac, 8'h00));
    pending_words.push_back(make_word(CmdWrite, 8'h00, AddrTac, 8'h05));
    pending_words.push_back(make_word(CmdWrite, 8'h00, AddrDiv, 8'hA5));
    // Remaining taps
    pending_words.push_back(make_word(CmdWrite, 8'h00, AddrTac, 8'h06));
    pending_words.push_back(make_word(CmdTick, 8'hFF, 16'h0000, 8'h00));
    pending_words.push_back(make_word(CmdWrite, 8'h00, AddrTac, 8'h07));
    pending_words.push_back(make_word(CmdTick, 8'hFF, 16'h0000, 8'h00));
    pending_words.push_back(make_word(CmdWrite, 8'h00, AddrTac, 8'h04));
    pending_words.push_back(make_word(CmdRead, 8'h00, AddrTima, 8'h00));
    for (int n = 0; n < RandomWords; n++) pending_words.push_back(random_word());

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every word to be taken and every result to arrive
    while (pending_words.size() != 0 || start_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/dtt_pkg.sv
rtl/core/dtt_step_unit.sv
rtl/core/dtt_seq.sv
rtl/core/div_tima_timer.sv
dv/div_tima_timer_test.sv
